@@ src/trl_pkg.sv @@
// trl_pkg: shared types and constants of the trilateration core
// no dependencies; used by the interfaces, the datapath modules and the checker
`timescale 1ns / 1ps

package trl_pkg;

    // field widths
    localparam int IN_W  = 24;
    localparam int CFG_W = 19;
    localparam int POS_W = 40;
    localparam int ST_W  = 3;

    // divider geometry: quotient bits, numerator and divisor magnitudes
    localparam int QW  = 40;
    localparam int NXW = 50;
    localparam int NYW = 76;
    localparam int DXW = 25;
    localparam int DYW = 49;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_TWO_ORIGIN = 3'd1,
        ST_TWO_AXIS   = 3'd2,
        ST_TWO_PLANE  = 3'd3,
        ST_DIST       = 3'd4,
        ST_ZERO_DIV   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ROLE_ORIGIN,
        ROLE_AXIS,
        ROLE_PLANE
    } t_role;

    // one lane of the bit-serial divider: partial remainder, numerator/quotient bits, divisor
    typedef struct packed {
        logic [DXW-1:0] rem;
        logic [QW-1:0]  qn;
        logic [DXW-1:0] den;
    } t_lane_x;

    typedef struct packed {
        logic [DYW-1:0] rem;
        logic [QW-1:0]  qn;
        logic [DYW-1:0] den;
    } t_lane_y;

    // sideband that travels with each transaction through the chain
    typedef struct packed {
        t_status status;
        logic    neg_x;
        logic    neg_y;
        logic    ovf_x;
        logic    ovf_y;
    } t_side;

endpackage

@@ src/trl_meas_if.sv @@
// trl_meas_if: measurement channel, valid/ready with three distances and sensor positions
// depends on trl_pkg for field widths
`timescale 1ns / 1ps

interface trl_meas_if;
    logic                       valid;
    logic                       ready;
    logic [trl_pkg::IN_W-1:0]   dist_a;
    logic [trl_pkg::IN_W-1:0]   dist_b;
    logic [trl_pkg::IN_W-1:0]   dist_c;
    logic [trl_pkg::IN_W-1:0]   sensor_a_x;
    logic [trl_pkg::IN_W-1:0]   sensor_a_y;
    logic [trl_pkg::IN_W-1:0]   sensor_b_x;
    logic [trl_pkg::IN_W-1:0]   sensor_b_y;
    logic [trl_pkg::IN_W-1:0]   sensor_c_x;
    logic [trl_pkg::IN_W-1:0]   sensor_c_y;

    modport source (
        output valid, dist_a, dist_b, dist_c,
               sensor_a_x, sensor_a_y, sensor_b_x, sensor_b_y, sensor_c_x, sensor_c_y,
        input  ready
    );
    modport sink (
        input  valid, dist_a, dist_b, dist_c,
               sensor_a_x, sensor_a_y, sensor_b_x, sensor_b_y, sensor_c_x, sensor_c_y,
        output ready
    );
endinterface

@@ src/trl_res_if.sv @@
// trl_res_if: result channel, valid/ready with solved position and status
// depends on trl_pkg for field widths
`timescale 1ns / 1ps

interface trl_res_if;
    logic                       valid;
    logic                       ready;
    logic [trl_pkg::POS_W-1:0]  pos_x;
    logic [trl_pkg::POS_W-1:0]  pos_y;
    logic [trl_pkg::ST_W-1:0]   status;

    modport source (output valid, pos_x, pos_y, status, input ready);
    modport sink   (input  valid, pos_x, pos_y, status, output ready);
endinterface

@@ src/trl_front.sv @@
// trl_front: role sort, range check, products and numerators, divider setup
// depends on trl_pkg and trl_meas_if; feeds the first divider cell
`timescale 1ns / 1ps

module trl_front #(
    parameter int DIST_LIMIT = 256000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    trl_meas_if.sink                          i_meas,
    input  logic signed [trl_pkg::CFG_W-1:0]  i_height,
    output logic                              o_valid,
    input  logic                              i_ready,
    output trl_pkg::t_lane_x                  o_lx,
    output trl_pkg::t_lane_y                  o_ly,
    output trl_pkg::t_side                    o_side
);

    localparam int W  = trl_pkg::IN_W;
    localparam int PW = 2 * W;
    localparam int ZW = 2 * trl_pkg::CFG_W;
    localparam int NXW = trl_pkg::NXW;
    localparam int NYW = trl_pkg::NYW;
    localparam int DXW = trl_pkg::DXW;
    localparam int DYW = trl_pkg::DYW;
    localparam int QW  = trl_pkg::QW;
    localparam int LW  = 25;
    localparam int HW  = NXW - LW;
    localparam logic signed [W:0] LIM = (W + 1)'(DIST_LIMIT);

    function automatic trl_pkg::t_role role_of(input logic [W-1:0] x, input logic [W-1:0] y);
        trl_pkg::t_role r;
        if (x == '0 && y == '0) begin
            r = trl_pkg::ROLE_ORIGIN;
        end else if (y == '0) begin
            r = trl_pkg::ROLE_AXIS;
        end else begin
            r = trl_pkg::ROLE_PLANE;
        end
        return r;
    endfunction

    function automatic trl_pkg::t_status dup_status(input trl_pkg::t_role r);
        trl_pkg::t_status s;
        unique case (r)
            trl_pkg::ROLE_ORIGIN: s = trl_pkg::ST_TWO_ORIGIN;
            trl_pkg::ROLE_AXIS:   s = trl_pkg::ST_TWO_AXIS;
            default:              s = trl_pkg::ST_TWO_PLANE;
        endcase
        return s;
    endfunction

    // stage handshake chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6;

    assign w_rdy6 = !r_v6 || i_ready;
    assign w_rdy5 = !r_v5 || w_rdy6;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign i_meas.ready = w_rdy1;
    assign o_valid = r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_meas.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
            if (w_rdy6) r_v6 <= r_v5;
        end
    end

    // stage 1: roles, status, selection and squares
    logic signed [W-1:0] n_d [3];
    logic        [W-1:0] n_x [3];
    logic        [W-1:0] n_y [3];
    trl_pkg::t_role      n_r [3];
    logic signed [W-1:0] n_d_o, n_d_a, n_d_p, n_bx, n_cx, n_cy;
    logic                n_far;
    trl_pkg::t_status    n_st1;

    assign n_d[0] = i_meas.dist_a;
    assign n_d[1] = i_meas.dist_b;
    assign n_d[2] = i_meas.dist_c;
    assign n_x[0] = i_meas.sensor_a_x;
    assign n_x[1] = i_meas.sensor_b_x;
    assign n_x[2] = i_meas.sensor_c_x;
    assign n_y[0] = i_meas.sensor_a_y;
    assign n_y[1] = i_meas.sensor_b_y;
    assign n_y[2] = i_meas.sensor_c_y;

    always_comb begin
        n_d_o = '0;
        n_d_a = '0;
        n_d_p = '0;
        n_bx  = '0;
        n_cx  = '0;
        n_cy  = '0;
        n_far = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n_r[k] = role_of(n_x[k], n_y[k]);
            if (((W + 1)'(n_d[k]) > LIM) || ((W + 1)'(n_d[k]) < -LIM)) begin
                n_far = 1'b1;
            end
        end
        for (int k = 2; k >= 0; k--) begin
            case (n_r[k])
                trl_pkg::ROLE_ORIGIN: n_d_o = n_d[k];
                trl_pkg::ROLE_AXIS: begin
                    n_d_a = n_d[k];
                    n_bx  = n_x[k];
                end
                default: begin
                    n_d_p = n_d[k];
                    n_cx  = n_x[k];
                    n_cy  = n_y[k];
                end
            endcase
        end
        // first sensor that repeats a role decides, then range, then divisor guard
        if (n_r[1] == n_r[0]) begin
            n_st1 = dup_status(n_r[1]);
        end else if (n_r[2] == n_r[0] || n_r[2] == n_r[1]) begin
            n_st1 = dup_status(n_r[2]);
        end else if (n_far) begin
            n_st1 = trl_pkg::ST_DIST;
        end else if (n_bx == '0 || n_cy == '0) begin
            n_st1 = trl_pkg::ST_ZERO_DIV;
        end else begin
            n_st1 = trl_pkg::ST_OK;
        end
    end

    logic signed [PW-1:0] r1_sq_o, r1_sq_a, r1_sq_p, r1_bx2, r1_cx2, r1_cy2, r1_bxcy;
    logic signed [ZW-1:0] r1_zz;
    logic signed [W-1:0]  r1_bx, r1_cx;
    trl_pkg::t_status     r1_st;

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_meas.valid) begin
            r1_sq_o <= n_d_o * n_d_o;
            r1_sq_a <= n_d_a * n_d_a;
            r1_sq_p <= n_d_p * n_d_p;
            r1_bx2  <= n_bx * n_bx;
            r1_cx2  <= n_cx * n_cx;
            r1_cy2  <= n_cy * n_cy;
            r1_bxcy <= n_bx * n_cy;
            r1_zz   <= i_height * i_height;
            r1_bx   <= n_bx;
            r1_cx   <= n_cx;
            r1_st   <= n_st1;
        end
    end

    // stage 2: height-corrected squares, numerators and divisors
    logic signed [NXW-1:0] n_s_o, n_s_a, n_s_p;
    assign n_s_o = NXW'(r1_sq_o) - NXW'(r1_zz);
    assign n_s_a = NXW'(r1_sq_a) - NXW'(r1_zz);
    assign n_s_p = NXW'(r1_sq_p) - NXW'(r1_zz);

    logic signed [NXW-1:0] r2_n1, r2_n3;
    logic signed [W-1:0]   r2_bx, r2_cx;
    logic signed [DXW-1:0] r2_dx;
    logic signed [DYW-1:0] r2_dy;
    trl_pkg::t_status      r2_st;

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r2_n1 <= n_s_o - n_s_a + NXW'(r1_bx2);
            r2_n3 <= n_s_o - n_s_p + NXW'(r1_cx2) + NXW'(r1_cy2);
            r2_bx <= r1_bx;
            r2_cx <= r1_cx;
            r2_dx <= {r1_bx, 1'b0};
            r2_dy <= {r1_bxcy, 1'b0};
            r2_st <= r1_st;
        end
    end

    // stage 3: partial products of the y numerator
    logic signed [HW+W-1:0]   r3_p3h, r3_p1h;
    logic signed [LW+W:0]     r3_p3l, r3_p1l;
    logic signed [NXW-1:0]    r3_n1;
    logic signed [DXW-1:0]    r3_dx;
    logic signed [DYW-1:0]    r3_dy;
    trl_pkg::t_status         r3_st;

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r3_p3h <= $signed(r2_n3[NXW-1:LW]) * r2_bx;
            r3_p3l <= $signed({1'b0, r2_n3[LW-1:0]}) * r2_bx;
            r3_p1h <= $signed(r2_n1[NXW-1:LW]) * r2_cx;
            r3_p1l <= $signed({1'b0, r2_n1[LW-1:0]}) * r2_cx;
            r3_n1  <= r2_n1;
            r3_dx  <= r2_dx;
            r3_dy  <= r2_dy;
            r3_st  <= r2_st;
        end
    end

    // stage 4: y numerator from the partial products
    logic signed [NYW-1:0] r4_ny;
    logic signed [NXW-1:0] r4_n1;
    logic signed [DXW-1:0] r4_dx;
    logic signed [DYW-1:0] r4_dy;
    trl_pkg::t_status      r4_st;

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r4_ny <= (NYW'(r3_p3h) <<< LW) + NYW'(r3_p3l)
                   - (NYW'(r3_p1h) <<< LW) - NYW'(r3_p1l);
            r4_n1 <= r3_n1;
            r4_dx <= r3_dx;
            r4_dy <= r3_dy;
            r4_st <= r3_st;
        end
    end

    // stage 5: magnitudes and quotient signs
    logic [NXW-1:0] r5_mx;
    logic [NYW-1:0] r5_my;
    logic [DXW-1:0] r5_mdx;
    logic [DYW-1:0] r5_mdy;
    logic           r5_negx, r5_negy;
    trl_pkg::t_status r5_st;

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r_v4) begin
            r5_mx   <= r4_n1[NXW-1] ? NXW'(-r4_n1) : NXW'(r4_n1);
            r5_my   <= r4_ny[NYW-1] ? NYW'(-r4_ny) : NYW'(r4_ny);
            r5_mdx  <= r4_dx[DXW-1] ? DXW'(-r4_dx) : DXW'(r4_dx);
            r5_mdy  <= r4_dy[DYW-1] ? DYW'(-r4_dy) : DYW'(r4_dy);
            r5_negx <= r4_n1[NXW-1] ^ r4_dx[DXW-1];
            r5_negy <= r4_ny[NYW-1] ^ r4_dy[DYW-1];
            r5_st   <= r4_st;
        end
    end

    // stage 6: overflow precheck and divider lane setup
    logic [DXW-1:0] n_topx;
    logic [DYW-1:0] n_topy;
    assign n_topx = {{(DXW - (NXW - QW)){1'b0}}, r5_mx[NXW-1:QW]};
    assign n_topy = {{(DYW - (NYW - QW)){1'b0}}, r5_my[NYW-1:QW]};

    trl_pkg::t_lane_x r6_lx;
    trl_pkg::t_lane_y r6_ly;
    trl_pkg::t_side   r6_side;

    always_ff @(posedge i_clk) begin
        if (w_rdy6 && r_v5) begin
            r6_lx.rem      <= n_topx;
            r6_lx.qn       <= r5_mx[QW-1:0];
            r6_lx.den      <= r5_mdx;
            r6_ly.rem      <= n_topy;
            r6_ly.qn       <= r5_my[QW-1:0];
            r6_ly.den      <= r5_mdy;
            r6_side.status <= r5_st;
            r6_side.neg_x  <= r5_negx;
            r6_side.neg_y  <= r5_negy;
            r6_side.ovf_x  <= n_topx >= r5_mdx;
            r6_side.ovf_y  <= n_topy >= r5_mdy;
        end
    end

    assign o_lx   = r6_lx;
    assign o_ly   = r6_ly;
    assign o_side = r6_side;

endmodule

@@ src/trl_cell.sv @@
// trl_cell: one divider cell, one quotient bit of the x and y divisions
// depends on trl_pkg; cells are chained by the top level
`timescale 1ns / 1ps

module trl_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  trl_pkg::t_lane_x i_lx,
    input  trl_pkg::t_lane_y i_ly,
    input  trl_pkg::t_side   i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output trl_pkg::t_lane_x o_lx,
    output trl_pkg::t_lane_y o_ly,
    output trl_pkg::t_side   o_side
);

    localparam int DXW = trl_pkg::DXW;
    localparam int DYW = trl_pkg::DYW;
    localparam int QW  = trl_pkg::QW;

    logic r_valid;
    trl_pkg::t_lane_x r_lx;
    trl_pkg::t_lane_y r_ly;
    trl_pkg::t_side   r_side;

    // restoring step, x lane
    logic [DXW:0] n_tx, n_subx;
    logic         n_gex;
    assign n_tx   = {i_lx.rem, i_lx.qn[QW-1]};
    assign n_subx = n_tx - {1'b0, i_lx.den};
    assign n_gex  = n_tx >= {1'b0, i_lx.den};

    // restoring step, y lane
    logic [DYW:0] n_ty, n_suby;
    logic         n_gey;
    assign n_ty   = {i_ly.rem, i_ly.qn[QW-1]};
    assign n_suby = n_ty - {1'b0, i_ly.den};
    assign n_gey  = n_ty >= {1'b0, i_ly.den};

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lx.rem <= n_gex ? n_subx[DXW-1:0] : n_tx[DXW-1:0];
            r_lx.qn  <= {i_lx.qn[QW-2:0], n_gex};
            r_lx.den <= i_lx.den;
            r_ly.rem <= n_gey ? n_suby[DYW-1:0] : n_ty[DYW-1:0];
            r_ly.qn  <= {i_ly.qn[QW-2:0], n_gey};
            r_ly.den <= i_ly.den;
            r_side   <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_lx    = r_lx;
    assign o_ly    = r_ly;
    assign o_side  = r_side;

endmodule

@@ src/trl_back.sv @@
// trl_back: rounding, saturation and error zeroing, result output register
// depends on trl_pkg and trl_res_if; fed by the last divider cell
`timescale 1ns / 1ps

module trl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  trl_pkg::t_lane_x i_lx,
    input  trl_pkg::t_lane_y i_ly,
    input  trl_pkg::t_side   i_side,
    trl_res_if.source        o_res
);

    localparam int QW = trl_pkg::QW;
    localparam int PW = trl_pkg::POS_W;
    localparam logic [PW:0]   Q_MAX   = {2'b00, {(PW - 1){1'b1}}};
    localparam logic [PW:0]   Q_MIN   = {2'b01, {(PW - 1){1'b0}}};
    localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW - 1){1'b1}}};
    localparam logic [PW-1:0] POS_MIN = {1'b1, {(PW - 1){1'b0}}};

    function automatic logic [PW-1:0] finish(input logic [QW-1:0] q, input logic rnd,
                                             input logic ovf, input logic neg);
        logic [PW:0]   qr;
        logic [PW-1:0] v;
        qr = {1'b0, PW'(q)} + (PW + 1)'(rnd);
        if (neg) begin
            v = (ovf || qr > Q_MIN) ? POS_MIN : PW'(-qr);
        end else begin
            v = (ovf || qr > Q_MAX) ? POS_MAX : qr[PW-1:0];
        end
        return v;
    endfunction

    // round half away from zero on the magnitude
    logic n_rndx, n_rndy;
    logic [PW-1:0] n_px, n_py;
    logic          n_ok;
    assign n_rndx = i_lx.rem >= (i_lx.den - i_lx.rem);
    assign n_rndy = i_ly.rem >= (i_ly.den - i_ly.rem);
    assign n_ok   = i_side.status == trl_pkg::ST_OK;
    assign n_px   = n_ok ? finish(i_lx.qn, n_rndx, i_side.ovf_x, i_side.neg_x) : '0;
    assign n_py   = n_ok ? finish(i_ly.qn, n_rndy, i_side.ovf_y, i_side.neg_y) : '0;

    logic r_valid;
    logic [PW-1:0] r_pos_x, r_pos_y;
    trl_pkg::t_status r_status;

    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pos_x  <= n_px;
            r_pos_y  <= n_py;
            r_status <= i_side.status;
        end
    end

    assign o_res.valid  = r_valid;
    assign o_res.pos_x  = r_pos_x;
    assign o_res.pos_y  = r_pos_y;
    assign o_res.status = r_status;

endmodule

@@ src/three_sensor_trilateration_core.sv @@
// path from an accepted measurement to its result on o_res:
// 6 setup stages, 40 divider cells, 1 output register
// throughput: one transaction per cycle unless o_res stalls; each divider cell
// resolves one quotient bit of both divisions, handing its remainder to the next cell
// reset: synchronous active-low i_rst_n clears all valid bits and the height offset
`timescale 1ns / 1ps

module three_sensor_trilateration_core #(
    parameter int DIST_LIMIT = 256000
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    trl_meas_if.sink                   i_meas,
    trl_res_if.source                  o_res,
    input  logic                       i_cfg_we,
    input  logic [trl_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int QW = trl_pkg::QW;

    // height offset register
    logic signed [trl_pkg::CFG_W-1:0] r_height_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height_offset <= '0;
        end else if (i_cfg_we) begin
            r_height_offset <= i_cfg_data;
        end
    end

    // links between front end, divider cells and back end
    logic             w_valid [QW+1];
    logic             w_ready [QW+1];
    trl_pkg::t_lane_x w_lx    [QW+1];
    trl_pkg::t_lane_y w_ly    [QW+1];
    trl_pkg::t_side   w_side  [QW+1];

    trl_front #(
        .DIST_LIMIT(DIST_LIMIT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_meas   (i_meas),
        .i_height (r_height_offset),
        .o_valid  (w_valid[0]),
        .i_ready  (w_ready[0]),
        .o_lx     (w_lx[0]),
        .o_ly     (w_ly[0]),
        .o_side   (w_side[0])
    );

    // chain of divider cells, one quotient bit each
    for (genvar k = 0; k < QW; k++) begin : g_cell
        trl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_lx    (w_lx[k]),
            .i_ly    (w_ly[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_lx    (w_lx[k+1]),
            .o_ly    (w_ly[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    trl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[QW]),
        .o_ready (w_ready[QW]),
        .i_lx    (w_lx[QW]),
        .i_ly    (w_ly[QW]),
        .i_side  (w_side[QW]),
        .o_res   (o_res)
    );

endmodule

@@ src/trl_checker.sv @@
// trl_checker: port-level assertions on the result channel of the core
// depends on trl_pkg; bound to three_sensor_trilateration_core below
`timescale 1ns / 1ps

module trl_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [trl_pkg::POS_W-1:0]  i_pos_x,
    input logic [trl_pkg::POS_W-1:0]  i_pos_y,
    input logic [trl_pkg::ST_W-1:0]   i_status
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_pos_x) && $stable(i_pos_y)
                                && $stable(i_status))
        else $error("result changed while stalled");

    // an error result carries a zero position
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != trl_pkg::ST_OK |-> i_pos_x == '0 && i_pos_y == '0)
        else $error("error result with nonzero position");

    // distinct roles always give nonzero divisors
    a_no_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_status != trl_pkg::ST_ZERO_DIV)
        else $error("zero divisor reported");

endmodule

bind three_sensor_trilateration_core trl_checker u_trl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_pos_x  (o_res.pos_x),
    .i_pos_y  (o_res.pos_y),
    .i_status (o_res.status)
);

@@ sim/trilateration_checker.sv @@
// trilateration_checker: watches the measurement and result channels, predicts each
// solved position from the measurement and the height offset, and counts mismatches
// depends on trl_pkg, trl_meas_if and trl_res_if
`timescale 1ns / 1ps

module trilateration_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    trl_meas_if                        i_meas,
    trl_res_if                         i_res,
    input  logic                       i_cfg_we,
    input  logic [trl_pkg::CFG_W-1:0]  i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import trl_pkg::*;

    typedef struct {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        t_status          status;
    } t_position;

    localparam longint LIMIT = 256000;

    t_position              expected_positions[$];
    logic signed [CFG_W-1:0] height_offset;

    // exact quotient, rounded half away from zero, saturated to 40 bits
    function automatic logic [POS_W-1:0] round_div_sat(logic signed [127:0] num,
                                                       logic signed [127:0] den);
        logic [127:0] n_mag;
        logic [127:0] d_mag;
        logic [127:0] quo;
        logic [127:0] rem;
        logic         neg;
        n_mag = num < 0 ? -num : num;
        d_mag = den < 0 ? -den : den;
        quo   = n_mag / d_mag;
        rem   = n_mag % d_mag;
        if (rem >= d_mag - rem) quo = quo + 1;
        neg = (num < 0) != (den < 0);
        if (neg) begin
            if (quo > (128'd1 << 39)) return {1'b1, {(POS_W-1){1'b0}}};
            return -quo[POS_W-1:0];
        end
        if (quo > (128'd1 << 39) - 1) return {1'b0, {(POS_W-1){1'b1}}};
        return quo[POS_W-1:0];
    endfunction

    // sort sensors into roles, range check, then solve x and y
    function automatic t_position solve_position(logic [IN_W-1:0] dists[3],
                                                 logic [IN_W-1:0] sx_raw[3],
                                                 logic [IN_W-1:0] sy_raw[3],
                                                 logic signed [CFG_W-1:0] z);
        t_position          res;
        int                 owner[3];
        int                 r;
        logic signed [127:0] d[3];
        logic signed [127:0] sx[3];
        logic signed [127:0] sy[3];
        logic signed [127:0] zz, s1, s2, s3, bx, cx, cy, n1, n3, zl;
        res.pos_x  = '0;
        res.pos_y  = '0;
        res.status = ST_OK;
        owner = '{-1, -1, -1};
        for (int k = 0; k < 3; k++) begin
            d[k]  = $signed(dists[k]);
            sx[k] = $signed(sx_raw[k]);
            sy[k] = $signed(sy_raw[k]);
        end
        for (int k = 0; k < 3 && res.status == ST_OK; k++) begin
            if (sx[k] == 0 && sy[k] == 0) r = ROLE_ORIGIN;
            else if (sy[k] == 0)           r = ROLE_AXIS;
            else                           r = ROLE_PLANE;
            if (owner[r] >= 0) begin
                case (r)
                    ROLE_ORIGIN: res.status = ST_TWO_ORIGIN;
                    ROLE_AXIS:   res.status = ST_TWO_AXIS;
                    default:     res.status = ST_TWO_PLANE;
                endcase
            end else begin
                owner[r] = k;
            end
        end
        if (res.status == ST_OK) begin
            for (int k = 0; k < 3; k++)
                if (d[k] > LIMIT || d[k] < -LIMIT) res.status = ST_DIST;
        end
        if (res.status == ST_OK) begin
            zl = z;
            zz = zl * zl;
            s1 = d[owner[ROLE_ORIGIN]] * d[owner[ROLE_ORIGIN]] - zz;
            s2 = d[owner[ROLE_AXIS]] * d[owner[ROLE_AXIS]] - zz;
            s3 = d[owner[ROLE_PLANE]] * d[owner[ROLE_PLANE]] - zz;
            bx = sx[owner[ROLE_AXIS]];
            cx = sx[owner[ROLE_PLANE]];
            cy = sy[owner[ROLE_PLANE]];
            if (bx == 0 || cy == 0) begin
                res.status = ST_ZERO_DIV;
            end else begin
                n1 = s1 - s2 + bx * bx;
                n3 = s1 - s3 + cx * cx + cy * cy;
                res.pos_x = round_div_sat(n1, 2 * bx);
                res.pos_y = round_div_sat(n3 * bx - cx * n1, 2 * bx * cy);
            end
        end
        return res;
    endfunction

    // offset register mirror
    always @(posedge i_clk) begin
        if (!i_rst_n) height_offset <= '0;
        else if (i_cfg_we) height_offset <= i_cfg_data;
    end

    // predict on accepted measurements, compare on accepted results
    initial o_fail_count = 0;
    always @(posedge i_clk) begin
        t_position       got;
        t_position       exp_pos;
        logic [IN_W-1:0] dists[3];
        logic [IN_W-1:0] sx[3];
        logic [IN_W-1:0] sy[3];
        if (i_rst_n && i_meas.valid && i_meas.ready) begin
            dists = '{i_meas.dist_a, i_meas.dist_b, i_meas.dist_c};
            sx    = '{i_meas.sensor_a_x, i_meas.sensor_b_x, i_meas.sensor_c_x};
            sy    = '{i_meas.sensor_a_y, i_meas.sensor_b_y, i_meas.sensor_c_y};
            expected_positions = {expected_positions,
                                  solve_position(dists, sx, sy, height_offset)};
        end
        if (i_rst_n && i_res.valid && i_res.ready) begin
            got.pos_x  = i_res.pos_x;
            got.pos_y  = i_res.pos_y;
            got.status = t_status'(i_res.status);
            if (expected_positions.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h status=%0d", $time,
                         got.pos_x, got.pos_y, got.status);
                o_fail_count <= o_fail_count + 1;
            end else begin
                exp_pos = expected_positions.pop_front();
                if (got.pos_x !== exp_pos.pos_x || got.pos_y !== exp_pos.pos_y ||
                    got.status !== exp_pos.status) begin
                    $display("%0t: mismatch expected x=%h y=%h status=%0d", $time,
                             exp_pos.pos_x, exp_pos.pos_y, exp_pos.status);
                    $display("%0t:          actual   x=%h y=%h status=%0d", $time,
                             got.pos_x, got.pos_y, got.status);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
        // outstanding transactions after this edge
        o_pending <= expected_positions.size();
    end

endmodule

@@ sim/three_sensor_trilateration_core_test.sv @@
// three_sensor_trilateration_core_test: drives measurement sets and offset writes
// into the trilateration core and gives the verdict from the checker's count
// depends on trl_pkg, trl_meas_if, trl_res_if, the core and trilateration_checker
`timescale 1ns / 1ps

module three_sensor_trilateration_core_test;
    import trl_pkg::*;

    localparam int DIST_LIMIT     = 256000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int LONG_HOLD      = 300;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_W-1:0]    i_cfg_data;
    int                  fail_count;
    int                  pending;
    int                  idle_pct;
    int                  stall_pct;
    bit                  hold_req;
    int                  quiet_cycles;
    logic [IN_W-1:0]     item[9];

    trl_meas_if meas ();
    trl_res_if  res ();

    three_sensor_trilateration_core #(.DIST_LIMIT(DIST_LIMIT)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_meas     (meas),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    trilateration_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_meas       (meas),
        .i_res        (res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result receiver with random stalls and one long hold-off
    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end
            res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((meas.valid && meas.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[three_sensor_trilateration_core] ERROR");
            $finish;
        end
    end

    // send one measurement set, with random idle cycles before it
    task automatic send_item();
        while ($urandom_range(99) < idle_pct) begin
            meas.valid <= 1'b0;
            @(posedge i_clk);
        end
        meas.valid      <= 1'b1;
        meas.dist_a     <= item[0];
        meas.dist_b     <= item[1];
        meas.dist_c     <= item[2];
        meas.sensor_a_x <= item[3];
        meas.sensor_a_y <= item[4];
        meas.sensor_b_x <= item[5];
        meas.sensor_b_y <= item[6];
        meas.sensor_c_x <= item[7];
        meas.sensor_c_y <= item[8];
        @(posedge i_clk);
        while (!meas.ready) @(posedge i_clk);
    endtask

    // wait for the pipe to drain, then write the offset
    task automatic write_offset(input logic [CFG_W-1:0] value);
        meas.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // place sensors: ra/rb/rc give the role of A, B, C
    task automatic place(input t_role ra, input t_role rb, input t_role rc,
                         input logic [IN_W-1:0] ax, input logic [IN_W-1:0] py,
                         input logic [IN_W-1:0] px);
        t_role roles[3];
        roles = '{ra, rb, rc};
        for (int k = 0; k < 3; k++) begin
            case (roles[k])
                ROLE_ORIGIN: begin item[3+2*k] = '0; item[4+2*k] = '0; end
                ROLE_AXIS:   begin item[3+2*k] = ax; item[4+2*k] = '0; end
                default:     begin item[3+2*k] = px; item[4+2*k] = py; end
            endcase
        end
    endtask

    function automatic logic [IN_W-1:0] rand_nonzero(bit wide);
        logic [IN_W-1:0] v;
        do begin
            if (wide) v = IN_W'($urandom);
            else      v = IN_W'($signed($urandom_range(131072)) - 65536);
        end while (v == '0);
        return v;
    endfunction

    function automatic logic [IN_W-1:0] rand_dist(bit wide);
        if (wide) return IN_W'($urandom);
        return IN_W'($signed($urandom_range(2 * DIST_LIMIT)) - DIST_LIMIT);
    endfunction

    // mostly well-formed sets in random role order, the rest noise
    task automatic make_random_item();
        t_role perm[3];
        int    sel;
        bit    wide;
        perm = '{ROLE_ORIGIN, ROLE_AXIS, ROLE_PLANE};
        perm.shuffle();
        sel  = $urandom_range(99);
        wide = ($urandom_range(9) == 0);
        for (int k = 0; k < 3; k++) item[k] = rand_dist($urandom_range(19) == 0);
        if (sel < 80) begin
            place(perm[0], perm[1], perm[2], rand_nonzero(wide), rand_nonzero(wide),
                  wide ? IN_W'($urandom) : IN_W'(rand_nonzero(0)));
        end else begin
            // random roles, often repeated
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(3))
                    0: begin item[3+2*k] = '0; item[4+2*k] = '0; end
                    1: begin item[3+2*k] = rand_nonzero(1); item[4+2*k] = '0; end
                    default: begin
                        item[3+2*k] = IN_W'($urandom);
                        item[4+2*k] = IN_W'($urandom);
                    end
                endcase
            end
        end
    endtask

    // directed corners
    task automatic run_directed();
        item[0] = 24'd2560; item[1] = 24'd3000; item[2] = 24'd2800;
        place(ROLE_ORIGIN, ROLE_AXIS, ROLE_PLANE, 24'd1280, 24'd1024, 24'd512);
        send_item();
        place(ROLE_PLANE, ROLE_ORIGIN, ROLE_AXIS, -24'sd1280, -24'sd768, 24'd300);
        send_item();
        place(ROLE_AXIS, ROLE_PLANE, ROLE_ORIGIN, 24'd1, 24'd1, -24'sd1);
        send_item();
        // role conflicts
        place(ROLE_ORIGIN, ROLE_ORIGIN, ROLE_PLANE, 24'd100, 24'd100, 24'd100);
        send_item();
        place(ROLE_AXIS, ROLE_PLANE, ROLE_AXIS, 24'd100, 24'd100, 24'd100);
        send_item();
        place(ROLE_PLANE, ROLE_PLANE, ROLE_PLANE, 24'd100, 24'd100, 24'd100);
        send_item();
        place(ROLE_ORIGIN, ROLE_ORIGIN, ROLE_ORIGIN, 24'd100, 24'd100, 24'd100);
        send_item();
        // distance limit edges, negative distances accepted
        place(ROLE_ORIGIN, ROLE_AXIS, ROLE_PLANE, 24'd5000, 24'd7000, 24'd3000);
        item[0] = IN_W'(DIST_LIMIT); item[1] = IN_W'(-DIST_LIMIT); item[2] = -24'sd100;
        send_item();
        item[0] = IN_W'(DIST_LIMIT + 1);
        send_item();
        item[0] = 24'd0; item[2] = IN_W'(-DIST_LIMIT - 1);
        send_item();
        item[1] = 24'h800000; item[2] = 24'h7FFFFF;
        send_item();
        // coordinate extremes, saturation of y and x
        item[0] = IN_W'(DIST_LIMIT); item[1] = 24'd0; item[2] = IN_W'(-DIST_LIMIT);
        place(ROLE_ORIGIN, ROLE_AXIS, ROLE_PLANE, 24'd1, 24'd1, 24'h7FFFFF);
        send_item();
        place(ROLE_ORIGIN, ROLE_AXIS, ROLE_PLANE, -24'sd1, 24'd1, 24'h800000);
        send_item();
        place(ROLE_PLANE, ROLE_AXIS, ROLE_ORIGIN, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_item();
        place(ROLE_AXIS, ROLE_ORIGIN, ROLE_PLANE, 24'h800000, 24'h7FFFFF, 24'h800000);
        send_item();
        item[0] = 24'd0; item[1] = 24'd0; item[2] = 24'd0;
        place(ROLE_ORIGIN, ROLE_AXIS, ROLE_PLANE, 24'd2, 24'd2, 24'd0);
        send_item();
        item[0] = 24'd3; item[1] = 24'd0; item[2] = 24'd1;
        send_item();
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        meas.valid <= 1'b0;
        meas.dist_a <= '0; meas.dist_b <= '0; meas.dist_c <= '0;
        meas.sensor_a_x <= '0; meas.sensor_a_y <= '0;
        meas.sensor_b_x <= '0; meas.sensor_b_y <= '0;
        meas.sensor_c_x <= '0; meas.sensor_c_y <= '0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b0;
        quiet_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        write_offset(CFG_W'(256000));
        run_directed();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_offset(CFG_W'(0));
                1: write_offset(CFG_W'(-256000));
                2: write_offset(CFG_W'(256000));
                3: write_offset(CFG_W'($urandom_range(512000) - 256000));
                default: write_offset(CFG_W'($urandom_range(4000)));
            endcase
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                3: begin idle_pct = 10; stall_pct = 10; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 0 && n == 20) hold_req = 1'b1;
                make_random_item();
                send_item();
            end
        end
        meas.valid <= 1'b0;

        // drain
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[three_sensor_trilateration_core] OK");
        end else begin
            $display("[three_sensor_trilateration_core] ERROR");
        end
        $finish;
    end

endmodule
